>>> rtl/core/solar_to_lunar_date_core_defines.svh
// Assertion macros shared by the solar to lunar date converter.
`ifndef SOLAR_TO_LUNAR_DATE_CORE_DEFINES_SVH
`define SOLAR_TO_LUNAR_DATE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STLD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/stld_pkg.sv
// Package with widths, the year table and date helper functions for the converter.
`timescale 1ns / 1ps
`default_nettype none

package stld_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WORD_W  = 24;
    localparam int DOY_W   = 9;
    localparam int SLOT_W  = 4;

    localparam int TABLE_YEARS = 199;
    localparam logic [YEAR_W-1:0] FIRST_YEAR = 12'd1901;
    localparam logic [YEAR_W-1:0] LAST_YEAR  = 12'd2099;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Number of month slots walked back from in a year without and with a leap month.
    localparam logic [SLOT_W-1:0] SLOTS_PLAIN = 4'd12;
    localparam logic [SLOT_W-1:0] SLOTS_LEAP  = 4'd13;
    localparam logic [SLOT_W-1:0] SLOT_FIRST  = 4'd1;

    localparam logic [DOY_W-1:0] LEN_SHORT = 9'd29;
    localparam logic [DOY_W-1:0] LEN_LONG  = 9'd30;

    // Spring Festival month field value that stands for January.
    localparam logic [1:0] SF_CODE_JAN = 2'd1;

    // Result of the shared subtract and compare unit.
    typedef struct packed {
        logic [DOY_W-1:0] diff;
        logic             ge;
    } t_alu_res;

    // One word per lunar year: leap month, thirteen month lengths, Spring Festival date.
    localparam logic [WORD_W-1:0] YEAR_ROM [0:TABLE_YEARS-1] = '{
        24'h04AE53,24'h0A5748,24'h5526BD,24'h0D2650,24'h0D9544,24'h46AAB9,24'h056A4D,
        24'h09AD42,24'h24AEB6,24'h04AE4A,24'h6A4DBE,24'h0A4D52,24'h0D2546,24'h5D52BA,
        24'h0B544E,24'h0D6A43,24'h296D37,24'h095B4B,24'h749BC1,24'h049754,24'h0A4B48,
        24'h5B25BC,24'h06A550,24'h06D445,24'h4ADAB8,24'h02B64D,24'h095742,24'h2497B7,
        24'h04974A,24'h664B3E,24'h0D4A51,24'h0EA546,24'h56D4BA,24'h05AD4E,24'h02B644,
        24'h393738,24'h092E4B,24'h7C96BF,24'h0C9553,24'h0D4A48,24'h6DA53B,24'h0B554F,
        24'h056A45,24'h4AADB9,24'h025D4D,24'h092D42,24'h2C95B6,24'h0A954A,24'h7B4ABD,
        24'h06CA51,24'h0B5546,24'h555ABB,24'h04DA4E,24'h0A5B43,24'h352BB8,24'h052B4C,
        24'h8A953F,24'h0E9552,24'h06AA48,24'h6AD53C,24'h0AB54F,24'h04B645,24'h4A5739,
        24'h0A574D,24'h052642,24'h3E9335,24'h0D9549,24'h75AABE,24'h056A51,24'h096D46,
        24'h54AEBB,24'h04AD4F,24'h0A4D43,24'h4D26B7,24'h0D254B,24'h8D52BF,24'h0B5452,
        24'h0B6A47,24'h696D3C,24'h095B50,24'h049B45,24'h4A4BB9,24'h0A4B4D,24'hAB25C2,
        24'h06A554,24'h06D449,24'h6ADA3D,24'h0AB651,24'h093746,24'h5497BB,24'h04974F,
        24'h064B44,24'h36A537,24'h0EA54A,24'h86B2BF,24'h05AC53,24'h0AB647,24'h5936BC,
        24'h092E50,24'h0C9645,24'h4D4AB8,24'h0D4A4C,24'h0DA541,24'h25AAB6,24'h056A49,
        24'h7AADBD,24'h025D52,24'h092D47,24'h5C95BA,24'h0A954E,24'h0B4A43,24'h4B5537,
        24'h0AD54A,24'h955ABF,24'h04BA53,24'h0A5B48,24'h652BBC,24'h052B50,24'h0A9345,
        24'h474AB9,24'h06AA4C,24'h0AD541,24'h24DAB6,24'h04B64A,24'h69573D,24'h0A4E51,
        24'h0D2646,24'h5E933A,24'h0D534D,24'h05AA43,24'h36B537,24'h096D4B,24'hB4AEBF,
        24'h04AD53,24'h0A4D48,24'h6D25BC,24'h0D254F,24'h0D5244,24'h5DAA38,24'h0B5A4C,
        24'h056D41,24'h24ADB6,24'h049B4A,24'h7A4BBE,24'h0A4B51,24'h0AA546,24'h5B52BA,
        24'h06D24E,24'h0ADA42,24'h355B37,24'h09374B,24'h8497C1,24'h049753,24'h064B48,
        24'h66A53C,24'h0EA54F,24'h06B244,24'h4AB638,24'h0AAE4C,24'h092E42,24'h3C9735,
        24'h0C9649,24'h7D4ABD,24'h0D4A51,24'h0DA545,24'h55AABA,24'h056A4E,24'h0A6D43,
        24'h452EB7,24'h052D4B,24'h8A95BF,24'h0A9553,24'h0B4A47,24'h6B553B,24'h0AD54F,
        24'h055A45,24'h4A5D38,24'h0A5B4C,24'h052B42,24'h3A93B6,24'h069349,24'h7729BD,
        24'h06AA51,24'h0AD546,24'h54DABA,24'h04B64E,24'h0A5743,24'h452738,24'h0D264A,
        24'h8E933E,24'h0D5252,24'h0DAA47,24'h66B53B,24'h056D4F,24'h04AE45,24'h4A4EB9,
        24'h0A4D4C,24'h0D1541,24'h2D92B5
    };

    // Days in a Gregorian month; zero for a month code that means nothing.
    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                       input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days of a common year that come before the first of the month.
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // Length of month slot 1 to 13, taken from bits 19 down to 7.
    function automatic logic [DOY_W-1:0] slot_len(input logic [WORD_W-1:0] w,
                                                  input logic [SLOT_W-1:0] slot);
        logic [4:0] idx;
        logic [DOY_W-1:0] len;
        idx = 5'd20 - {1'b0, slot};
        if (slot < SLOT_FIRST || slot > SLOTS_LEAP) begin
            len = LEN_SHORT;
        end else begin
            len = w[idx] ? LEN_LONG : LEN_SHORT;
        end
        return len;
    endfunction

    // Month number of a slot; the leap month shares the number of the one before it.
    function automatic logic [MONTH_W-1:0] slot_month(input logic [WORD_W-1:0] w,
                                                      input logic [SLOT_W-1:0] slot);
        logic [3:0] leap;
        leap = w[23:20];
        return (leap != 4'd0 && slot > leap) ? slot - 4'd1 : slot;
    endfunction

    // Day of the year, counted from zero, on which Spring Festival falls.
    function automatic logic [DOY_W-1:0] spring_offset(input logic [WORD_W-1:0] w);
        logic [DOY_W-1:0] sd;
        sd = {4'd0, w[4:0]};
        return (w[6:5] == SF_CODE_JAN) ? sd - 9'd1 : sd + 9'd30;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/stld_in_if.sv
// Input channel interface carrying one Gregorian date per word.
`timescale 1ns / 1ps
`default_nettype none

interface stld_in_if;
    logic                             valid;
    logic                             ready;
    logic [stld_pkg::YEAR_W-1:0]      solar_year;
    logic [stld_pkg::MONTH_W-1:0]     solar_month;
    logic [stld_pkg::DAY_W-1:0]       solar_day;

    modport source (output valid, output solar_year, output solar_month, output solar_day,
                    input ready);
    modport sink   (input valid, input solar_year, input solar_month, input solar_day,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/stld_out_if.sv
// Output channel interface carrying one lunar date result per word.
`timescale 1ns / 1ps
`default_nettype none

interface stld_out_if;
    logic                             valid;
    logic                             ready;
    logic                             date_ok;
    logic [stld_pkg::YEAR_W-1:0]      lunar_year;
    logic [stld_pkg::MONTH_W-1:0]     lunar_month;
    logic [stld_pkg::DAY_W-1:0]       lunar_day;

    modport source (output valid, output date_ok, output lunar_year, output lunar_month,
                    output lunar_day, input ready);
    modport sink   (input valid, input date_ok, input lunar_year, input lunar_month,
                    input lunar_day, output ready);
endinterface

`default_nettype wire

>>> rtl/core/stld_alu.sv
// Shared subtract and compare unit used by every step of the date walk.
`timescale 1ns / 1ps
`default_nettype none

module stld_alu (
    input  logic [stld_pkg::DOY_W-1:0] i_a,
    input  logic [stld_pkg::DOY_W-1:0] i_b,
    output stld_pkg::t_alu_res         o_res
);

    logic [stld_pkg::DOY_W:0] full;

    // One borrow chain gives both the difference and the a >= b flag.
    assign full       = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff = full[stld_pkg::DOY_W-1:0];
    assign o_res.ge   = ~full[stld_pkg::DOY_W];

endmodule

`default_nettype wire

>>> rtl/core/stld_rom.sv
// Year table with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module stld_rom #(
    parameter int  P_TABLE_YEARS = stld_pkg::TABLE_YEARS,
    localparam int IDX_W         = (P_TABLE_YEARS > 1) ? $clog2(P_TABLE_YEARS) : 1
) (
    input  logic                        i_clk,
    input  logic [IDX_W-1:0]            i_addr,
    output logic [stld_pkg::WORD_W-1:0] o_word
);

    logic [stld_pkg::WORD_W-1:0] r_word;

    always_ff @(posedge i_clk) begin
        if (int'(i_addr) < P_TABLE_YEARS) begin
            r_word <= stld_pkg::YEAR_ROM[i_addr];
        end else begin
            r_word <= '0;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

>>> rtl/core/solar_to_lunar_date_core.sv
// Top level of the Gregorian to Chinese lunar date converter.
//
//  Channel | Direction | Payload                                        | Handshake
//  i_in    | in        | solar_year, solar_month, solar_day             | valid / ready
//  o_out   | out       | date_ok, lunar_year, lunar_month, lunar_day    | valid / ready
//
// An invalid date goes from the check step straight to the output register, as does a 1901
// date before Spring Festival after the direction step; other words walk the slots forward or back,
// one subtract and compare per cycle on the shared unit setting the walk's pace.
// i_rst_n is synchronous and active low; it empties the sequencer and the output register.
// The input is ready only while the sequencer is idle. A result waiting in the output register
// does not block the next word; a second result holds in the final step until it is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "solar_to_lunar_date_core_defines.svh"

module solar_to_lunar_date_core #(
    parameter int P_TABLE_YEARS = stld_pkg::TABLE_YEARS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    stld_in_if.sink         i_in,
    stld_out_if.source      o_out
);

    localparam int IDX_W = (P_TABLE_YEARS > 1) ? $clog2(P_TABLE_YEARS) : 1;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,  // waiting for a word
        S_CHECK = 9'b0_0000_0010,  // validate the date, form the day of the year
        S_DIR   = 9'b0_0000_0100,  // compare with Spring Festival, pick the direction
        S_FWD   = 9'b0_0000_1000,  // forward walk, one slot per cycle
        S_BINIT = 9'b0_0001_0000,  // distance back to Spring Festival
        S_BLOAD = 9'b0_0010_0000,  // previous year's word arrives
        S_BWD   = 9'b0_0100_0000,  // backward walk, one slot per cycle
        S_BFIN  = 9'b0_1000_0000,  // day within the slot reached
        S_PUSH  = 9'b1_0000_0000   // hand the result to the output register
    } t_state;

    t_state                               r_state, n_state;
    logic [stld_pkg::YEAR_W-1:0]          r_year, n_year;
    logic [stld_pkg::MONTH_W-1:0]         r_month, n_month;
    logic [stld_pkg::DAY_W-1:0]           r_day, n_day;
    logic [IDX_W-1:0]                     r_addr, n_addr;
    logic [stld_pkg::DOY_W-1:0]           r_doy, n_doy;
    logic [stld_pkg::DOY_W-1:0]           r_spr, n_spr;
    logic [stld_pkg::WORD_W-1:0]          r_word, n_word;
    logic [stld_pkg::SLOT_W-1:0]          r_slot, n_slot;
    logic [stld_pkg::DOY_W-1:0]           r_rem, n_rem;

    logic                                 r_res_ok, n_res_ok;
    logic [stld_pkg::YEAR_W-1:0]          r_res_year, n_res_year;
    logic [stld_pkg::MONTH_W-1:0]         r_res_month, n_res_month;
    logic [stld_pkg::DAY_W-1:0]           r_res_day, n_res_day;

    logic                                 r_out_valid, n_out_valid;
    logic                                 r_out_ok, n_out_ok;
    logic [stld_pkg::YEAR_W-1:0]          r_out_year, n_out_year;
    logic [stld_pkg::MONTH_W-1:0]         r_out_month, n_out_month;
    logic [stld_pkg::DAY_W-1:0]           r_out_day, n_out_day;

    logic [stld_pkg::WORD_W-1:0]          rom_word;
    logic [stld_pkg::YEAR_W-1:0]          in_year_off;
    logic [stld_pkg::YEAR_W-1:0]          year_off;
    logic                                 leap_year;
    logic                                 date_valid;
    logic [stld_pkg::DOY_W-1:0]           doy_calc;
    logic [stld_pkg::DOY_W-1:0]           cur_len;
    logic [stld_pkg::DOY_W-1:0]           alu_a, alu_b;
    stld_pkg::t_alu_res                   alu_res;
    logic                                 in_accept;

    stld_rom #(
        .P_TABLE_YEARS (P_TABLE_YEARS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_addr),
        .o_word (rom_word)
    );

    stld_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_accept  = i_in.valid && i_in.ready;

    assign in_year_off = i_in.solar_year - stld_pkg::FIRST_YEAR;
    assign year_off    = r_year - stld_pkg::FIRST_YEAR;

    // Every valid year lies in 1901 to 2099, where the Gregorian rule reduces to
    // divisibility by four; outside that span the year is rejected anyway.
    assign leap_year = (r_year[1:0] == 2'b00);

    assign date_valid = (r_year >= stld_pkg::FIRST_YEAR) && (r_year <= stld_pkg::LAST_YEAR)
                     && (int'(year_off) < P_TABLE_YEARS)
                     && (r_month >= stld_pkg::MONTH_JAN) && (r_month <= stld_pkg::MONTH_DEC)
                     && (r_day != '0)
                     && (r_day <= stld_pkg::days_in_month(r_month, leap_year));

    assign doy_calc = stld_pkg::days_before(r_month) + {4'd0, r_day} - 9'd1
                    + {8'd0, (leap_year && r_month > stld_pkg::MONTH_FEB)};

    assign cur_len = stld_pkg::slot_len(r_word, r_slot);

    // Operand selection for the shared unit.
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        unique case (r_state)
            S_DIR: begin
                alu_a = r_doy;
                alu_b = stld_pkg::spring_offset(rom_word);
            end
            S_BINIT: begin
                alu_a = r_spr;
                alu_b = r_doy;
            end
            S_FWD, S_BWD: begin
                alu_a = r_rem;
                alu_b = cur_len;
            end
            S_BFIN: begin
                alu_a = cur_len;
                alu_b = r_rem;
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_addr      = r_addr;
        n_doy       = r_doy;
        n_spr       = r_spr;
        n_word      = r_word;
        n_slot      = r_slot;
        n_rem       = r_rem;
        n_res_ok    = r_res_ok;
        n_res_year  = r_res_year;
        n_res_month = r_res_month;
        n_res_day   = r_res_day;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_ok    = r_out_ok;
        n_out_year  = r_out_year;
        n_out_month = r_out_month;
        n_out_day   = r_out_day;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_year  = i_in.solar_year;
                    n_month = i_in.solar_month;
                    n_day   = i_in.solar_day;
                    n_addr  = in_year_off[IDX_W-1:0];
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_doy = doy_calc;
                if (date_valid) begin
                    n_state = S_DIR;
                end else begin
                    n_res_ok    = 1'b0;
                    n_res_year  = '0;
                    n_res_month = '0;
                    n_res_day   = '0;
                    n_state     = S_PUSH;
                end
            end
            S_DIR: begin
                n_word = rom_word;
                n_spr  = alu_b;
                if (alu_res.ge) begin
                    n_rem   = alu_res.diff;
                    n_slot  = stld_pkg::SLOT_FIRST;
                    n_state = S_FWD;
                end else if (r_year == stld_pkg::FIRST_YEAR) begin
                    // The lunar year before the table's first one is not held.
                    n_res_ok    = 1'b0;
                    n_res_year  = '0;
                    n_res_month = '0;
                    n_res_day   = '0;
                    n_state     = S_PUSH;
                end else begin
                    n_addr  = r_addr - IDX_W'(1);
                    n_state = S_BINIT;
                end
            end
            S_FWD: begin
                if (alu_res.ge && r_slot < stld_pkg::SLOTS_LEAP) begin
                    n_rem  = alu_res.diff;
                    n_slot = r_slot + 4'd1;
                end else begin
                    n_res_ok    = 1'b1;
                    n_res_year  = r_year;
                    n_res_month = stld_pkg::slot_month(r_word, r_slot);
                    n_res_day   = r_rem[stld_pkg::DAY_W-1:0] + 5'd1;
                    n_state     = S_PUSH;
                end
            end
            S_BINIT: begin
                n_rem   = alu_res.diff;
                n_state = S_BLOAD;
            end
            S_BLOAD: begin
                n_word  = rom_word;
                n_slot  = (rom_word[23:20] == 4'd0) ? stld_pkg::SLOTS_PLAIN
                                                    : stld_pkg::SLOTS_LEAP;
                n_state = S_BWD;
            end
            S_BWD: begin
                // Step back while the distance still exceeds the slot length.
                if (alu_res.ge && alu_res.diff != '0 && r_slot > stld_pkg::SLOT_FIRST) begin
                    n_rem  = alu_res.diff;
                    n_slot = r_slot - 4'd1;
                end else begin
                    n_state = S_BFIN;
                end
            end
            S_BFIN: begin
                n_res_ok    = 1'b1;
                n_res_year  = r_year - 12'd1;
                n_res_month = stld_pkg::slot_month(r_word, r_slot);
                n_res_day   = alu_res.diff[stld_pkg::DAY_W-1:0] + 5'd1;
                n_state     = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_year  = r_res_year;
                    n_out_month = r_res_month;
                    n_out_day   = r_res_day;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_year      <= n_year;
        r_month     <= n_month;
        r_day       <= n_day;
        r_addr      <= n_addr;
        r_doy       <= n_doy;
        r_spr       <= n_spr;
        r_word      <= n_word;
        r_slot      <= n_slot;
        r_rem       <= n_rem;
        r_res_ok    <= n_res_ok;
        r_res_year  <= n_res_year;
        r_res_month <= n_res_month;
        r_res_day   <= n_res_day;
        r_out_ok    <= n_out_ok;
        r_out_year  <= n_out_year;
        r_out_month <= n_out_month;
        r_out_day   <= n_out_day;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.date_ok     = r_out_ok;
    assign o_out.lunar_year  = r_out_year;
    assign o_out.lunar_month = r_out_month;
    assign o_out.lunar_day   = r_out_day;

    // An accepted word always starts with the validation step.
    `STLD_ASSERT_NEXT(a_accept_to_check, i_clk, i_rst_n, in_accept, r_state == S_CHECK, "accepted word did not enter the check step")

    // A rejected date leaves every lunar field at zero.
    `STLD_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, o_out.valid && !o_out.date_ok, o_out.lunar_year == '0 && o_out.lunar_month == '0 && o_out.lunar_day == '0, "rejected date carries non-zero lunar fields")

    // The walks never leave the thirteen month slots of a year.
    `STLD_ASSERT_NOW(a_slot_range, i_clk, i_rst_n, r_state == S_FWD || r_state == S_BWD, r_slot >= stld_pkg::SLOT_FIRST && r_slot <= stld_pkg::SLOTS_LEAP, "month slot outside one to thirteen")

endmodule

`default_nettype wire

>>> dv/solar_to_lunar_date_core_checker.sv
// Checker that predicts the lunar date of every accepted word and compares it with the result.
`timescale 1ns / 1ps

module solar_to_lunar_date_core_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    stld_in_if   i_in_mon,
    stld_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import stld_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_lunar_date;

    // Own copy of the year words, so that a slip in the design's table shows up here.
    localparam logic [WORD_W-1:0] LUNAR_WORDS [0:TABLE_YEARS-1] = '{
        24'h04AE53,24'h0A5748,24'h5526BD,24'h0D2650,24'h0D9544,24'h46AAB9,24'h056A4D,
        24'h09AD42,24'h24AEB6,24'h04AE4A,24'h6A4DBE,24'h0A4D52,24'h0D2546,24'h5D52BA,
        24'h0B544E,24'h0D6A43,24'h296D37,24'h095B4B,24'h749BC1,24'h049754,24'h0A4B48,
        24'h5B25BC,24'h06A550,24'h06D445,24'h4ADAB8,24'h02B64D,24'h095742,24'h2497B7,
        24'h04974A,24'h664B3E,24'h0D4A51,24'h0EA546,24'h56D4BA,24'h05AD4E,24'h02B644,
        24'h393738,24'h092E4B,24'h7C96BF,24'h0C9553,24'h0D4A48,24'h6DA53B,24'h0B554F,
        24'h056A45,24'h4AADB9,24'h025D4D,24'h092D42,24'h2C95B6,24'h0A954A,24'h7B4ABD,
        24'h06CA51,24'h0B5546,24'h555ABB,24'h04DA4E,24'h0A5B43,24'h352BB8,24'h052B4C,
        24'h8A953F,24'h0E9552,24'h06AA48,24'h6AD53C,24'h0AB54F,24'h04B645,24'h4A5739,
        24'h0A574D,24'h052642,24'h3E9335,24'h0D9549,24'h75AABE,24'h056A51,24'h096D46,
        24'h54AEBB,24'h04AD4F,24'h0A4D43,24'h4D26B7,24'h0D254B,24'h8D52BF,24'h0B5452,
        24'h0B6A47,24'h696D3C,24'h095B50,24'h049B45,24'h4A4BB9,24'h0A4B4D,24'hAB25C2,
        24'h06A554,24'h06D449,24'h6ADA3D,24'h0AB651,24'h093746,24'h5497BB,24'h04974F,
        24'h064B44,24'h36A537,24'h0EA54A,24'h86B2BF,24'h05AC53,24'h0AB647,24'h5936BC,
        24'h092E50,24'h0C9645,24'h4D4AB8,24'h0D4A4C,24'h0DA541,24'h25AAB6,24'h056A49,
        24'h7AADBD,24'h025D52,24'h092D47,24'h5C95BA,24'h0A954E,24'h0B4A43,24'h4B5537,
        24'h0AD54A,24'h955ABF,24'h04BA53,24'h0A5B48,24'h652BBC,24'h052B50,24'h0A9345,
        24'h474AB9,24'h06AA4C,24'h0AD541,24'h24DAB6,24'h04B64A,24'h69573D,24'h0A4E51,
        24'h0D2646,24'h5E933A,24'h0D534D,24'h05AA43,24'h36B537,24'h096D4B,24'hB4AEBF,
        24'h04AD53,24'h0A4D48,24'h6D25BC,24'h0D254F,24'h0D5244,24'h5DAA38,24'h0B5A4C,
        24'h056D41,24'h24ADB6,24'h049B4A,24'h7A4BBE,24'h0A4B51,24'h0AA546,24'h5B52BA,
        24'h06D24E,24'h0ADA42,24'h355B37,24'h09374B,24'h8497C1,24'h049753,24'h064B48,
        24'h66A53C,24'h0EA54F,24'h06B244,24'h4AB638,24'h0AAE4C,24'h092E42,24'h3C9735,
        24'h0C9649,24'h7D4ABD,24'h0D4A51,24'h0DA545,24'h55AABA,24'h056A4E,24'h0A6D43,
        24'h452EB7,24'h052D4B,24'h8A95BF,24'h0A9553,24'h0B4A47,24'h6B553B,24'h0AD54F,
        24'h055A45,24'h4A5D38,24'h0A5B4C,24'h052B42,24'h3A93B6,24'h069349,24'h7729BD,
        24'h06AA51,24'h0AD546,24'h54DABA,24'h04B64E,24'h0A5743,24'h452738,24'h0D264A,
        24'h8E933E,24'h0D5252,24'h0DAA47,24'h66B53B,24'h056D4F,24'h04AE45,24'h4A4EB9,
        24'h0A4D4C,24'h0D1541,24'h2D92B5
    };

    localparam int MONTH_DAYS [0:11] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int DAYS_AHEAD [0:11] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    t_lunar_date expected_q[$];
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    // A set bit in the month field means a 30-day month, slot 1 sitting at bit 19.
    function automatic int moon_days(input logic [WORD_W-1:0] w, input int slot);
        return w[20 - slot] ? 30 : 29;
    endfunction

    // The leap month carries the number of the month it follows.
    function automatic logic [MONTH_W-1:0] moon_number(input logic [WORD_W-1:0] w,
                                                       input int slot);
        int                 leap_slot;
        logic [MONTH_W-1:0] num;
        leap_slot = int'(w[23:20]);
        num = MONTH_W'((leap_slot != 0 && slot > leap_slot) ? slot - 1 : slot);
        return num;
    endfunction

    function automatic t_lunar_date lunar_of(input logic [YEAR_W-1:0]  sy,
                                             input logic [MONTH_W-1:0] sm,
                                             input logic [DAY_W-1:0]   sd);
        t_lunar_date      r;
        logic [WORD_W-1:0] w;
        logic             leap_year;
        int               yi, mi, di, dim, doy, sf_doy, rest, slot, len;
        r  = '0;
        yi = int'(sy);
        mi = int'(sm);
        di = int'(sd);
        if (yi < int'(FIRST_YEAR) || yi > int'(LAST_YEAR)
            || yi - int'(FIRST_YEAR) >= TABLE_YEARS) return r;
        if (mi < 1 || mi > 12 || di < 1) return r;
        leap_year = ((yi % 4) == 0 && (yi % 100) != 0) || (yi % 400) == 0;
        dim = MONTH_DAYS[mi - 1];
        if (sm == MONTH_FEB && leap_year) dim = 29;
        if (di > dim) return r;

        w      = LUNAR_WORDS[yi - int'(FIRST_YEAR)];
        sf_doy = (w[6:5] == SF_CODE_JAN) ? int'(w[4:0]) - 1 : int'(w[4:0]) + 30;
        doy    = DAYS_AHEAD[mi - 1] + di - 1;
        if (leap_year && mi > 2) doy++;

        if (doy >= sf_doy) begin
            // Walk forward from Spring Festival of this year.
            rest = doy - sf_doy;
            slot = 1;
            len  = moon_days(w, slot);
            while (rest >= len && slot < int'(SLOTS_LEAP)) begin
                rest -= len;
                slot++;
                len = moon_days(w, slot);
            end
            r.year = sy;
            r.day  = DAY_W'(rest + 1);
        end else begin
            // Before Spring Festival: walk back from the end of the previous lunar year.
            if (yi == int'(FIRST_YEAR)) return r;
            w    = LUNAR_WORDS[yi - 1 - int'(FIRST_YEAR)];
            rest = sf_doy - doy;
            slot = (w[23:20] == 4'd0) ? int'(SLOTS_PLAIN) : int'(SLOTS_LEAP);
            len  = moon_days(w, slot);
            while (rest > len && slot > 1) begin
                rest -= len;
                slot--;
                len = moon_days(w, slot);
            end
            r.year = sy - YEAR_W'(1);
            r.day  = DAY_W'(len - rest + 1);
        end
        r.month = moon_number(w, slot);
        r.ok    = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_lunar_date want;
        if (i_rst_n) begin
            // Results are retired before new words are queued: no result can belong to a
            // word accepted at the same edge.
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_q.size() == 0) begin
                    if (fail_total < 10)
                        $display("unexpected result: ok=%0d %0d-%0d-%0d", i_out_mon.date_ok,
                                 i_out_mon.lunar_year, i_out_mon.lunar_month,
                                 i_out_mon.lunar_day);
                    fail_total++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_mon.date_ok !== want.ok || i_out_mon.lunar_year !== want.year
                        || i_out_mon.lunar_month !== want.month
                        || i_out_mon.lunar_day !== want.day) begin
                        if (fail_total < 10)
                            $display("mismatch: expected ok=%0d %0d-%0d-%0d, got ok=%0d %0d-%0d-%0d",
                                     want.ok, want.year, want.month, want.day,
                                     i_out_mon.date_ok, i_out_mon.lunar_year,
                                     i_out_mon.lunar_month, i_out_mon.lunar_day);
                        fail_total++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                expected_q.push_back(lunar_of(i_in_mon.solar_year, i_in_mon.solar_month,
                                              i_in_mon.solar_day));
        end
        o_pending <= expected_q.size();
    end

endmodule

>>> dv/solar_to_lunar_date_core_tb.sv
// Testbench top: drives dates into the converter, stalls the result side and gives the verdict.
`timescale 1ns / 1ps

module solar_to_lunar_date_core_tb;
    import stld_pkg::*;

    // A few hundred words with heavy idling on either side finish well inside the cycle limit.
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_WORDS = 500;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;

    logic i_clk;
    logic i_rst_n;
    int   tx_idle_pct  = 10;
    int   rx_stall_pct = 80;
    int   cycle_count  = 0;
    int   fail_count;
    int   pending;

    stld_in_if  in_ch ();
    stld_out_if out_ch ();

    solar_to_lunar_date_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // The checker watches both channels and keeps its own count of what is still owed.
    solar_to_lunar_date_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // A run that hangs, for instance because a result never appears, is stopped here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL solar_to_lunar_date_core");
            $finish;
        end
    end

    // The result side takes a word only when ready is high; the stall rate changes by phase.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Offers one date and returns at the edge where it is taken. Valid is left high, so a
    // following word goes straight on without a gap unless the idle draw says otherwise.
    task automatic send_date(input logic [YEAR_W-1:0]  y,
                             input logic [MONTH_W-1:0] m,
                             input logic [DAY_W-1:0]   d);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.solar_year  <= y;
        in_ch.solar_month <= m;
        in_ch.solar_day   <= d;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;
        int                 pick;

        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.solar_year  = '0;
        in_ch.solar_month = '0;
        in_ch.solar_day   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: field extremes, dates either side of the table's edges and of
        // Spring Festival, the Gregorian leap rules, and a leap lunar month.
        send_date(12'd0, 4'd0, 5'd0);
        send_date(12'd4095, 4'd15, 5'd31);
        send_date(12'd1900, 4'd12, 5'd31);
        send_date(12'd2100, 4'd1, 5'd1);
        send_date(12'd1901, 4'd1, 5'd1);        // before the first Spring Festival
        send_date(12'd1901, 4'd2, 5'd18);
        send_date(12'd1901, 4'd2, 5'd19);       // the first Spring Festival itself
        send_date(12'd1901, 4'd2, 5'd29);       // not a leap year
        send_date(12'd2000, 4'd2, 5'd29);       // leap by the four-hundred rule
        send_date(12'd1904, 4'd2, 5'd29);
        send_date(12'd1901, 4'd4, 5'd31);       // thirty-day month
        send_date(12'd1950, 4'd13, 5'd1);
        send_date(12'd1950, 4'd0, 5'd5);
        send_date(12'd1950, 4'd6, 5'd0);
        send_date(12'd2099, 4'd12, 5'd31);
        send_date(12'd2099, 4'd1, 5'd1);
        send_date(12'd1904, 4'd1, 5'd1);        // walks back through a year with a leap month
        send_date(12'd1906, 4'd1, 5'd25);       // Spring Festival falls in January
        send_date(12'd1906, 4'd1, 5'd24);
        send_date(12'd1903, 4'd6, 5'd25);       // first day of a leap month
        send_date(12'd1903, 4'd7, 5'd23);
        send_date(12'd1903, 4'd7, 5'd24);
        send_date(12'd1999, 4'd1, 5'd31);
        send_date(12'd2048, 4'd12, 5'd31);

        // Random words in three phases: slow receiver, then slow sender, then neither idles.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 10;
                    rx_stall_pct = 80;
                end
                1: begin
                    tx_idle_pct  = 80;
                    rx_stall_pct = 10;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < (RANDOM_WORDS + 2) / 3; n++) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    // Mostly plausible dates; day 31 now and then lands past a short month.
                    y = YEAR_W'($urandom_range(int'(LAST_YEAR), int'(FIRST_YEAR)));
                    m = MONTH_W'($urandom_range(12, 1));
                    d = DAY_W'($urandom_range(31, 1));
                end else if (pick < 80) begin
                    // Early in the year, around Spring Festival, where the backward walk lives.
                    y = YEAR_W'($urandom_range(int'(LAST_YEAR), int'(FIRST_YEAR)));
                    m = MONTH_W'($urandom_range(3, 1));
                    d = DAY_W'($urandom_range(31, 1));
                end else begin
                    // Noise over the whole width of every field.
                    y = YEAR_W'($urandom);
                    m = MONTH_W'($urandom);
                    d = DAY_W'($urandom);
                end
                send_date(y, m, d);
            end
        end
        in_ch.valid <= 1'b0;

        // Let the owed results come out, then give the block time to show anything stray.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS solar_to_lunar_date_core");
        end else begin
            $display("FAIL solar_to_lunar_date_core");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/stld_pkg.sv
rtl/core/stld_in_if.sv
rtl/core/stld_out_if.sv
rtl/core/stld_alu.sv
rtl/core/stld_rom.sv
rtl/core/solar_to_lunar_date_core.sv
dv/solar_to_lunar_date_core_checker.sv
dv/solar_to_lunar_date_core_tb.sv
